/* rtl/grht_pkg.sv */
// ============================================================================
// grht_pkg: shared types and constants for the generational handle table
// Action and status codes, slot row layout, item and result records.
// ============================================================================
package grht_pkg;

    localparam logic [31:0] REFS_FREE         = 32'hFFFF_FFFF;
    localparam logic [31:0] REFS_DESTROYING   = 32'hFFFF_FFFE;
    localparam logic [31:0] REFS_ADDREF_LIMIT = 32'hFFFF_FFFD;

    localparam int DATA_W = 208;

    typedef enum logic [2:0] {
        ACT_CREATE  = 3'd0,
        ACT_ADDREF  = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_QUERY   = 3'd3,
        ACT_RECORD  = 3'd4,
        ACT_CLAIM   = 3'd5,
        ACT_FINISH  = 3'd6
    } grht_action_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_INVALID   = 3'd1,
        STS_FULL      = 3'd2,
        STS_BAD_INIT  = 3'd3,
        STS_NO_CLAIM  = 3'd4
    } grht_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EXEC
    } grht_state_t;

    typedef struct packed {
        logic [31:0] gen;
        logic [31:0] refs;
        logic [63:0] payload;
    } grht_slot_t;

    typedef struct packed {
        grht_action_t action;
        logic [9:0]   slot_index;
        logic [31:0]  gen;
        logic [31:0]  init;
        logic [63:0]  payload;
        logic [1:0]   queue;
        logic [63:0]  fence;
    } grht_item_t;

    typedef struct packed {
        grht_status_t status;
        logic [9:0]   index;
        logic [31:0]  gen;
        logic [31:0]  ref_count;
        logic [63:0]  payload;
        logic [63:0]  last_use;
        logic         retire;
    } grht_result_t;

    typedef struct packed {
        logic slot_we;
        logic fence_we;
        logic push;
        logic pop;
        logic use_pop;
    } grht_wb_t;

endpackage

/* rtl/grht_ram.sv */
// ============================================================================
// grht_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data held when idle.
// ============================================================================
module grht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/grht_exec.sv */
// ============================================================================
// grht_exec: action decode and slot update
// Checks the handle against the read slot row and builds result and write-back.
// ============================================================================
module grht_exec
    import grht_pkg::*;
#(
    parameter int QUEUE_COUNT = 3
) (
    input  grht_item_t                   item,
    input  grht_slot_t                   slot_rd,
    input  logic [QUEUE_COUNT-1:0][63:0] fence_rd,
    input  logic                         in_range,
    input  logic                         stack_empty,
    input  logic [9:0]                   pop_slot,
    output grht_result_t                 res,
    output grht_wb_t                     wb,
    output grht_slot_t                   slot_wdata,
    output logic [QUEUE_COUNT-1:0][63:0] fence_wdata
);

    logic        match;
    logic        addref_ok;
    logic        queue_ok;
    logic [63:0] lane;
    logic [31:0] refs;
    logic [31:0] next_gen;

    always_comb
    begin
        refs      = slot_rd.refs;
        match     = in_range && (slot_rd.gen == item.gen) && (item.gen != 32'd0);
        addref_ok = match && (refs != 32'd0) && (refs < REFS_ADDREF_LIMIT);
        queue_ok  = 32'(item.queue) < QUEUE_COUNT;
        next_gen  = item.gen + 32'd1;
        if (next_gen == 32'd0)
        begin
            next_gen = 32'd1;
        end
        lane = '0;
        for (int q = 0; q < QUEUE_COUNT; q++)
        begin
            if (32'(item.queue) == q)
            begin
                lane = fence_rd[q];
            end
        end

        res           = '0;
        res.status    = STS_INVALID;
        res.index     = item.slot_index;
        res.gen       = item.gen;
        wb            = '0;
        slot_wdata    = slot_rd;
        fence_wdata   = fence_rd;

        unique case (item.action)
            ACT_CREATE:
            begin
                res.index = '0;
                res.gen   = '0;
                wb.use_pop = 1'b1;
                if ((item.init == 32'd0) || (item.init >= REFS_DESTROYING))
                begin
                    res.status = STS_BAD_INIT;
                end
                else if (stack_empty)
                begin
                    res.status = STS_FULL;
                end
                else
                begin
                    res.status         = STS_OK;
                    res.index          = pop_slot;
                    res.gen            = slot_rd.gen;
                    res.ref_count      = item.init;
                    slot_wdata.refs    = item.init;
                    slot_wdata.payload = item.payload;
                    fence_wdata        = '0;
                    wb.slot_we         = 1'b1;
                    wb.fence_we        = 1'b1;
                    wb.pop             = 1'b1;
                end
            end
            ACT_ADDREF:
            begin
                if (addref_ok)
                begin
                    res.status      = STS_OK;
                    res.ref_count   = refs + 32'd1;
                    slot_wdata.refs = refs + 32'd1;
                    wb.slot_we      = 1'b1;
                end
            end
            ACT_RELEASE:
            begin
                if (match && (refs != 32'd0) && (refs < REFS_DESTROYING))
                begin
                    res.status      = STS_OK;
                    res.ref_count   = refs - 32'd1;
                    res.retire      = (refs == 32'd1);
                    slot_wdata.refs = refs - 32'd1;
                    wb.slot_we      = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                if (match && (refs < REFS_DESTROYING))
                begin
                    res.status    = STS_OK;
                    res.ref_count = refs;
                    res.payload   = slot_rd.payload;
                    res.last_use  = queue_ok ? lane : 64'd0;
                end
            end
            ACT_RECORD:
            begin
                if ((item.fence != 64'd0) && queue_ok && addref_ok)
                begin
                    res.status    = STS_OK;
                    res.ref_count = refs;
                    for (int q = 0; q < QUEUE_COUNT; q++)
                    begin
                        if ((32'(item.queue) == q) && (fence_rd[q] < item.fence))
                        begin
                            fence_wdata[q] = item.fence;
                        end
                    end
                    wb.fence_we = 1'b1;
                end
            end
            ACT_CLAIM:
            begin
                if (match)
                begin
                    if (refs == 32'd0)
                    begin
                        res.status      = STS_OK;
                        res.payload     = slot_rd.payload;
                        slot_wdata.refs = REFS_DESTROYING;
                        wb.slot_we      = 1'b1;
                    end
                    else
                    begin
                        res.status = STS_NO_CLAIM;
                    end
                end
            end
            ACT_FINISH:
            begin
                if (match)
                begin
                    if (refs == REFS_DESTROYING)
                    begin
                        res.status  = STS_OK;
                        slot_wdata  = '{gen: next_gen, refs: REFS_FREE, payload: 64'd0};
                        fence_wdata = '0;
                        wb.slot_we  = 1'b1;
                        wb.fence_we = 1'b1;
                        wb.push     = 1'b1;
                    end
                    else
                    begin
                        res.status = STS_NO_CLAIM;
                    end
                end
            end
            default:
            begin
                res.status = STS_INVALID;
            end
        endcase
    end

endmodule

/* rtl/generational_refcount_handle_table.sv */
// ============================================================================
// generational_refcount_handle_table: slot table of generation-tagged handles
// Reference counts, payload words and per-queue last-use fences in RAM.
// ============================================================================
// Each item is handled alone: create goes through accept with free stack
// read, slot row read, and execute with write back; every other action
// goes through accept with slot and fence row read, and execute. The
// steps come from the registered reads of the slot, fence and free-stack
// RAMs plus a single read-modify-write per item; no item overlaps another,
// so no forwarding is needed. The result sits in an output register, so
// the next item is taken while a result waits. After reset and after every
// write of active_slots a clearing pass rewrites all SLOT_COUNT rows of
// every RAM; no item is taken during it.
module generational_refcount_handle_table
    import grht_pkg::*;
#(
    parameter int SLOT_COUNT  = 1024,
    parameter int QUEUE_COUNT = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [10:0]       cfg_wdata,   // active_slots
    input  logic              s_tvalid,
    output logic              s_tready,
    // slot_index[9:0], handle_generation[41:10], initial_count[73:42],
    // payload_word[137:74], fence_value[201:138], zero pad to 208
    input  logic [DATA_W-1:0] s_tdata,
    // action[2:0], queue_select[4:3]
    input  logic [4:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // out_index[9:0], out_generation[41:10], ref_count[73:42],
    // payload_out[137:74], last_use[201:138], zero pad to 208
    output logic [DATA_W-1:0] m_tdata,
    // status[2:0], retire[3]
    output logic [3:0]        m_tuser
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int FENCE_W = QUEUE_COUNT * 64;

    grht_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [CNT_W-1:0]     active_reg, active_next;
    logic [CNT_W-1:0]     top_reg, top_next;
    logic                 m_valid_reg, m_valid_next;
    grht_item_t           item_reg;
    grht_result_t         res_reg;

    // memory ports
    logic                         slot_we, slot_re;
    logic [IDX_W-1:0]             slot_waddr, slot_raddr;
    grht_slot_t                   slot_wdata, slot_rdata;
    logic                         fence_we, fence_re;
    logic [IDX_W-1:0]             fence_waddr, fence_raddr;
    logic [QUEUE_COUNT-1:0][63:0] fence_wdata, fence_rdata;
    logic                         stack_we, stack_re;
    logic [IDX_W-1:0]             stack_waddr, stack_raddr, stack_wdata, stack_rdata;

    // execute unit
    grht_result_t                 ex_res;
    grht_wb_t                     ex_wb;
    grht_slot_t                   ex_slot_wdata;
    logic [QUEUE_COUNT-1:0][63:0] ex_fence_wdata;
    logic                         in_range;
    logic                         s_accept;
    logic                         commit;
    logic                         push_ok;
    logic [31:0]                  cfg_value;
    logic [CNT_W-1:0]             clr_fill;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
    assign in_range = 32'(item_reg.slot_index) < 32'(active_reg);
    assign push_ok  = top_reg < CNT_W'(SLOT_COUNT);
    // free stack entry i below active_slots starts as active_slots-1-i, higher entries as 0
    assign clr_fill = active_reg - CNT_W'(1) - CNT_W'(clr_reg);

    grht_exec #(
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_exec (
        .item        (item_reg),
        .slot_rd     (slot_rdata),
        .fence_rd    (fence_rdata),
        .in_range    (in_range),
        .stack_empty (top_reg == '0),
        .pop_slot    (10'(stack_rdata)),
        .res         (ex_res),
        .wb          (ex_wb),
        .slot_wdata  (ex_slot_wdata),
        .fence_wdata (ex_fence_wdata)
    );

    grht_ram #(.WIDTH($bits(grht_slot_t)), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    grht_ram #(.WIDTH(FENCE_W), .DEPTH(SLOT_COUNT)) u_fence_ram (
        .clk   (clk),
        .we    (fence_we),
        .waddr (fence_waddr),
        .wdata (fence_wdata),
        .re    (fence_re),
        .raddr (fence_raddr),
        .rdata (fence_rdata)
    );

    grht_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // next state
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        active_next  = active_reg;
        top_next     = top_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cfg_value    = {21'd0, cfg_wdata};
        if (cfg_value == 32'd0)
        begin
            cfg_value = 32'd1;
        end
        if (cfg_value > 32'(SLOT_COUNT))
        begin
            cfg_value = 32'(SLOT_COUNT);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (s_tuser[2:0] == ACT_CREATE) ? ST_POP : ST_EXEC;
                end
            end
            ST_POP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    if (ex_wb.pop)
                    begin
                        top_next = top_reg - CNT_W'(1);
                    end
                    else if (ex_wb.push && push_ok)
                    begin
                        top_next = top_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // register write restarts the table
        if (cfg_we)
        begin
            active_next = CNT_W'(cfg_value);
            top_next    = CNT_W'(cfg_value);
            clr_next    = '0;
            state_next  = ST_CLEAR;
        end
    end

    // memory controls
    always_comb
    begin
        slot_we     = 1'b0;
        slot_re     = 1'b0;
        slot_waddr  = clr_reg;
        slot_raddr  = IDX_W'(s_tdata[9:0]);
        slot_wdata  = ex_slot_wdata;
        fence_we    = 1'b0;
        fence_re    = 1'b0;
        fence_waddr = clr_reg;
        fence_raddr = IDX_W'(s_tdata[9:0]);
        fence_wdata = ex_fence_wdata;
        stack_we    = 1'b0;
        stack_re    = 1'b0;
        stack_waddr = clr_reg;
        stack_raddr = IDX_W'(top_reg - CNT_W'(1));
        stack_wdata = IDX_W'(item_reg.slot_index);

        unique case (state_reg)
            ST_CLEAR:
            begin
                slot_we     = 1'b1;
                fence_we    = 1'b1;
                stack_we    = 1'b1;
                slot_wdata  = '{gen: 32'd1, refs: REFS_FREE, payload: 64'd0};
                fence_wdata = '0;
                stack_wdata = (CNT_W'(clr_reg) < active_reg) ? IDX_W'(clr_fill) : '0;
            end
            ST_IDLE:
            begin
                slot_re  = s_accept;
                fence_re = s_accept;
                stack_re = s_accept;
            end
            ST_POP:
            begin
                // popped slot index is now on the stack read port
                slot_re    = 1'b1;
                slot_raddr = stack_rdata;
            end
            ST_EXEC:
            begin
                slot_we     = commit && ex_wb.slot_we;
                fence_we    = commit && ex_wb.fence_we;
                stack_we    = commit && ex_wb.push && push_ok;
                slot_waddr  = ex_wb.use_pop ? stack_rdata : IDX_W'(item_reg.slot_index);
                fence_waddr = slot_waddr;
                stack_waddr = IDX_W'(top_reg);
            end
            default:
            begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            active_reg  <= CNT_W'(SLOT_COUNT);
            top_reg     <= CNT_W'(SLOT_COUNT);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            active_reg  <= active_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item and result payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.action     <= grht_action_t'(s_tuser[2:0]);
            item_reg.queue      <= s_tuser[4:3];
            item_reg.slot_index <= s_tdata[9:0];
            item_reg.gen        <= s_tdata[41:10];
            item_reg.init       <= s_tdata[73:42];
            item_reg.payload    <= s_tdata[137:74];
            item_reg.fence      <= s_tdata[201:138];
        end
        if (commit)
        begin
            res_reg <= ex_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_reg.last_use, res_reg.payload, res_reg.ref_count,
                       res_reg.gen, res_reg.index};
    assign m_tuser  = {res_reg.retire, res_reg.status};

endmodule

/* rtl/grht_checker.sv */
// ============================================================================
// grht_checker: port-level checks for the handle table
// Watches handshakes, clearing pass and result consistency.
// ============================================================================
module grht_checker
    import grht_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_we,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [3:0]        m_tuser
);

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still in work");

    // register write starts the clearing pass
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("item taken right after table reinit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // retire only on a successful release that hit zero
    a_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3]) |-> ((m_tuser[2:0] == STS_OK) && (m_tdata[73:42] == 32'd0)))
        else $error("retire with bad status or nonzero count");

endmodule

bind generational_refcount_handle_table grht_checker u_grht_checker (.*);
